>>> hdl/svt_pkg.sv
// ----------------------------------------------------------------------------
// svt_pkg: shared types and constants for the sorted value table
// Table size, index widths, status codes, sequencer states and the
// request bundle that the sequencer sends to the entry store.
// ----------------------------------------------------------------------------
package svt_pkg;

   localparam int CAPACITY = 16;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int HELD_W   = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 5;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [ADDR_W-1:0]         addr_type;
   typedef logic [HELD_W-1:0]         held_type;

   typedef enum logic {
      MODE_INSERT = 1'b0,
      MODE_REMOVE = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_CMP,
      S_REM_RD,
      S_REM_CMP,
      S_DONE
   } state_type;

   typedef struct packed {
      logic      wr_en;
      addr_type  wr_addr;
      value_type wr_data;
      addr_type  rd_addr;
   } store_req_type;

endpackage

>>> hdl/svt_if.sv
// ----------------------------------------------------------------------------
// svt_req_if / svt_rsp_if: valid/ready channels of the sorted value table
// Request carries operation and value; response carries status, count,
// smallest entry and empty flag.
// ----------------------------------------------------------------------------
interface svt_req_if import svt_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      mode;
   value_type value;

   modport source (output valid, output mode, output value, input ready);
   modport sink   (input valid, input mode, input value, output ready);
endinterface

interface svt_rsp_if import svt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [COUNT_W-1:0] count;
   value_type          smallest;
   logic               empty_res;

   modport source (output valid, output status, output count, output smallest,
                   output empty_res, input ready);
   modport sink   (input valid, input status, input count, input smallest,
                   input empty_res, output ready);
endinterface

>>> hdl/sorted_value_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_value_table_unit: bounded ascending table with insert and remove
// Insert walks down from the top entry, shifting larger entries up by one;
// remove walks up from entry zero, closing the gap behind the match.
// ----------------------------------------------------------------------------
// Steps: refused operations (insert into a full table, remove from an empty
//   one) go straight to the response; otherwise each step is one memory read
//   plus one compare in the shared comparator.
// Throughput: one transaction at a time; ready only while the sequencer idles,
//   so a new request waits until the previous response is loaded into the
//   output slot, which a response stall delays. Reset: synchronous, clears
//   count and handshake state; entries stay as they are and are only read
//   below the count.
// ----------------------------------------------------------------------------
module sorted_value_table_unit import svt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   svt_req_if.sink      req_chan,
   svt_rsp_if.source    rsp_chan
);

   state_type     state_ff, state_in;
   held_type      held_ff, held_in;
   addr_type      idx_ff, idx_in;
   logic          found_ff, found_in;
   value_type     value_ff, value_in;
   status_type    status_ff, status_in;

   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff;
   held_type      rsp_held_ff;
   value_type     rsp_smallest_ff;

   store_req_type store_req;
   value_type     rd_data;
   value_type     smallest;
   logic          cmp_less, cmp_equal;
   logic          accept;
   logic          rsp_load;
   addr_type      last_idx;

   svt_store u_store (
      .clock    (clock),
      .req      (store_req),
      .rd_data  (rd_data),
      .smallest (smallest)
   );

   svt_cmp u_cmp (
      .a     (value_ff),
      .b     (rd_data),
      .less  (cmp_less),
      .equal (cmp_equal)
   );

   assign req_chan.ready = state_ff == S_IDLE;
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_load       = state_ff == S_DONE && (!rsp_valid_ff || rsp_chan.ready);
   assign last_idx       = ADDR_W'(held_ff - 1'b1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_chan.mode == MODE_INSERT) begin
                  state_in = (held_ff >= HELD_W'(CAPACITY)) ? S_DONE : S_INS_RD;
               end else begin
                  state_in = (held_ff == '0) ? S_DONE : S_REM_RD;
               end
            end
         end
         S_INS_RD: begin
            state_in = (idx_ff == '0) ? S_DONE : S_INS_CMP;
         end
         S_INS_CMP: begin
            state_in = cmp_less ? S_INS_RD : S_DONE;
         end
         S_REM_RD: begin
            state_in = S_REM_CMP;
         end
         S_REM_CMP: begin
            state_in = (idx_ff == last_idx) ? S_DONE : S_REM_RD;
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath and store control
   always_comb begin
      held_in           = held_ff;
      idx_in            = idx_ff;
      found_in          = found_ff;
      value_in          = value_ff;
      status_in         = status_ff;
      store_req.wr_en   = 1'b0;
      store_req.wr_addr = idx_ff;
      store_req.wr_data = value_ff;
      store_req.rd_addr = idx_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               value_in  = req_chan.value;
               found_in  = 1'b0;
               status_in = STATUS_DONE;
               if (req_chan.mode == MODE_INSERT) begin
                  idx_in = ADDR_W'(held_ff);
                  if (held_ff >= HELD_W'(CAPACITY)) begin
                     status_in = STATUS_FULL;
                  end
               end else begin
                  idx_in = '0;
                  if (held_ff == '0) begin
                     status_in = STATUS_NOT_FOUND;
                  end
               end
            end
         end
         S_INS_RD: begin
            store_req.rd_addr = idx_ff - 1'b1;
            if (idx_ff == '0) begin
               // reached the bottom: new value becomes the smallest
               store_req.wr_en = 1'b1;
               held_in         = held_ff + 1'b1;
            end
         end
         S_INS_CMP: begin
            store_req.wr_en = 1'b1;
            if (cmp_less) begin
               // shift the larger entry up one slot
               store_req.wr_data = rd_data;
               idx_in            = idx_ff - 1'b1;
            end else begin
               held_in = held_ff + 1'b1;
            end
         end
         S_REM_RD: begin
            store_req.rd_addr = idx_ff;
         end
         S_REM_CMP: begin
            store_req.wr_addr = idx_ff - 1'b1;
            store_req.wr_data = rd_data;
            if (!found_ff && cmp_equal) begin
               found_in = 1'b1;
            end else if (found_ff) begin
               // close the gap left by the match
               store_req.wr_en = 1'b1;
            end
            if (idx_ff == last_idx) begin
               if (found_ff || cmp_equal) begin
                  held_in = held_ff - 1'b1;
               end else begin
                  status_in = STATUS_NOT_FOUND;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // output slot
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      found_ff  <= found_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      if (rsp_load) begin
         rsp_status_ff   <= status_ff;
         rsp_held_ff     <= held_ff;
         rsp_smallest_ff <= (held_ff != '0) ? smallest : '0;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.count     = COUNT_W'(rsp_held_ff);
   assign rsp_chan.smallest  = rsp_smallest_ff;
   assign rsp_chan.empty_res = rsp_held_ff == '0;

endmodule

>>> hdl/svt_cmp.sv
// ----------------------------------------------------------------------------
// svt_cmp: shared signed comparator
// Gives signed less-than and equality of the operand against one entry.
// ----------------------------------------------------------------------------
module svt_cmp import svt_pkg::*; (
   input  value_type a,
   input  value_type b,
   output logic      less,
   output logic      equal
);

   assign less  = a < b;
   assign equal = a == b;

endmodule

>>> hdl/svt_store.sv
// ----------------------------------------------------------------------------
// svt_store: entry memory of the sorted value table
// One write and one registered read per cycle; also tracks entry zero so
// the smallest value is available without a read.
// ----------------------------------------------------------------------------
module svt_store import svt_pkg::*; (
   input  logic          clock,
   input  store_req_type req,
   output value_type     rd_data,
   output value_type     smallest
);

   value_type mem [CAPACITY];
   value_type rd_data_ff;
   value_type smallest_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      rd_data_ff <= mem[req.rd_addr];
   end

   // mirror of entry zero
   always_ff @(posedge clock) begin
      if (req.wr_en && req.wr_addr == '0) begin
         smallest_ff <= req.wr_data;
      end
   end

   assign rd_data  = rd_data_ff;
   assign smallest = smallest_ff;

endmodule

>>> verif/tb_sorted_value_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_value_table_unit: self-checking bench for the sorted value table
// Inserts and removes values through the request channel and checks every
// response against a queue-based table model kept in step at each accepted
// request. A directed opening covers the empty, duplicate, absent and full
// cases; random traffic then swings the table between empty and full. Both
// channels idle in short random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module tb_sorted_value_table_unit;
   import svt_pkg::*;

   localparam int  HALF_PERIOD  = 10;
   localparam int  RESET_CYCLES = 9;
   localparam int  RANDOM_OPS   = 1825;
   localparam int  QUIET_TAIL   = 250;
   localparam int  DRAIN_CYCLES = 40;
   localparam int  STALL_LIMIT  = 4000;

   localparam value_type VALUE_MIN = 32'sh8000_0000;
   localparam value_type VALUE_MAX = 32'sh7fff_ffff;

   typedef struct {
      mode_type  mode;
      value_type value;
   } table_op_type;

   typedef struct {
      status_type         status;
      logic [COUNT_W-1:0] count;
      value_type          smallest;
      logic               empty_res;
   } table_result_type;

   logic clock;
   logic reset;

   svt_req_if req_if ();
   svt_rsp_if rsp_if ();

   sorted_value_table_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   table_op_type     pending_ops[$];
   table_result_type expected_results[$];
   value_type        sorted_values[$];
   int               error_count = 0;
   int               req_gap     = 0;
   int               rsp_stall   = 0;
   int               quiet_cycles = 0;

   always #(HALF_PERIOD) clock = ~clock;

   function automatic bit idling_enabled();
      return pending_ops.size() > QUIET_TAIL;
   endfunction

   // Apply one operation to the table model and return the response it gives.
   function automatic table_result_type apply_table_op(mode_type mode, value_type value);
      table_result_type res;
      int               pos;
      pos = 0;
      res.status = STATUS_DONE;
      if (mode == MODE_INSERT) begin
         if (sorted_values.size() >= CAPACITY) begin
            res.status = STATUS_FULL;
         end else begin
            // equal values stay ahead of the new one
            while (pos < sorted_values.size() && !(value < sorted_values[pos]))
               pos++;
            sorted_values.insert(pos, value);
         end
      end else begin
         while (pos < sorted_values.size() && sorted_values[pos] != value)
            pos++;
         if (pos >= sorted_values.size())
            res.status = STATUS_NOT_FOUND;
         else
            sorted_values.delete(pos);
      end
      res.count     = COUNT_W'(sorted_values.size());
      res.smallest  = (sorted_values.size() > 0) ? sorted_values[0] : '0;
      res.empty_res = (sorted_values.size() == 0);
      return res;
   endfunction

   task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   // Queue one op; track a loose copy of the contents to aim removes at hits.
   task automatic add_op(mode_type mode, value_type value, ref value_type held_guess[$]);
      table_op_type op;
      op.mode  = mode;
      op.value = value;
      pending_ops.push_back(op);
      if (mode == MODE_INSERT) begin
         if (held_guess.size() < CAPACITY)
            held_guess.push_back(value);
      end else begin
         foreach (held_guess[i])
            if (held_guess[i] == value) begin
               held_guess.delete(i);
               break;
            end
      end
   endtask

   // Small values often so duplicates and hits are common, plus extremes and full range.
   function automatic value_type random_value();
      case ($urandom_range(0, 9))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2, 3, 4: return $signed($urandom_range(0, 8)) - 4;
         default: return value_type'($urandom);
      endcase
   endfunction

   // Request driver: predict on acceptance, then hold, idle or load the next op.
   always @(posedge clock) begin : req_driver
      table_op_type next_op;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_results.push_back(
               apply_table_op(mode_type'(req_if.mode), req_if.value));
            if (idling_enabled() && $urandom_range(0, 4) == 0)
               req_gap = $urandom_range(1, 6);
         end
         if (!req_if.valid || req_if.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_if.valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
               next_op = pending_ops.pop_front();
               req_if.valid <= 1'b1;
               req_if.mode  <= next_op.mode;
               req_if.value <= next_op.value;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: compare each transaction with the oldest expectation.
   always @(posedge clock) begin : rsp_monitor
      table_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected response: status %0d count %0d smallest %0d",
                      rsp_if.status, rsp_if.count, rsp_if.smallest);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("status", want.status, rsp_if.status);
               check_field("count", want.count, rsp_if.count);
               check_field("smallest", want.smallest, rsp_if.smallest);
               check_field("empty_res", want.empty_res, rsp_if.empty_res);
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_if.ready <= 1'b0;
         end else if (idling_enabled() && $urandom_range(0, 7) == 0) begin
            rsp_stall = $urandom_range(1, 6) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      value_type held_guess[$];
      int        insert_weight;
      clock         = 1'b0;
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.mode   = MODE_INSERT;
      req_if.value  = '0;
      rsp_if.ready  = 1'b0;
      insert_weight = 50;

      add_op(MODE_REMOVE, 0, held_guess);
      add_op(MODE_INSERT, 0, held_guess);
      add_op(MODE_INSERT, VALUE_MAX, held_guess);
      add_op(MODE_INSERT, VALUE_MIN, held_guess);
      add_op(MODE_INSERT, -1, held_guess);
      add_op(MODE_INSERT, 0, held_guess);
      add_op(MODE_REMOVE, 1, held_guess);
      add_op(MODE_REMOVE, 0, held_guess);
      add_op(MODE_REMOVE, VALUE_MIN, held_guess);
      add_op(MODE_INSERT, VALUE_MIN, held_guess);
      // fill the table, one duplicate of the top value among them
      for (int i = 0; i < 11; i++)
         add_op(MODE_INSERT, i * 1000 - 6000, held_guess);
      add_op(MODE_INSERT, VALUE_MAX, held_guess);
      add_op(MODE_INSERT, 5, held_guess);
      add_op(MODE_REMOVE, VALUE_MAX, held_guess);
      add_op(MODE_INSERT, 32'sh5555_aaaa, held_guess);
      add_op(MODE_REMOVE, VALUE_MIN, held_guess);

      for (int n = 0; n < RANDOM_OPS; n++) begin
         // shift the insert bias now and then so the table swings empty to full
         if (n % 40 == 0)
            case ($urandom_range(0, 2))
               0: insert_weight = 20;
               1: insert_weight = 50;
               default: insert_weight = 80;
            endcase
         if ($urandom_range(1, 100) <= insert_weight)
            add_op(MODE_INSERT, random_value(), held_guess);
         else if (held_guess.size() > 0 && $urandom_range(0, 4) != 0)
            add_op(MODE_REMOVE, held_guess[$urandom_range(0, held_guess.size() - 1)],
                   held_guess);
         else
            add_op(MODE_REMOVE, random_value(), held_guess);
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() > 0 || req_if.valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/svt_pkg.sv
hdl/svt_if.sv
hdl/svt_cmp.sv
hdl/svt_store.sv
hdl/sorted_value_table_unit.sv
verif/tb_sorted_value_table_unit.sv
